FILE: src/deadline_priority_queue_defines.svh
// Assertion macros shared by the deadline priority queue RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef DEADLINE_PRIORITY_QUEUE_DEFINES_SVH
`define DEADLINE_PRIORITY_QUEUE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define DPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define DPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: src/dpq_pkg.sv
// Types and constants for the deadline priority queue.
// Depends on nothing.
package dpq_pkg;
   localparam int unsigned DefaultDepth = 8;
   localparam logic [15:0] IdleDeadline = 16'd9999;
   localparam logic        ActInsert = 1'b0;
   localparam logic        ActPop = 1'b1;

   typedef struct packed {
      logic        action;
      logic [7:0]  task_id;
      logic [15:0] deadline;
      logic [15:0] compute_time;
   } req_type;

   typedef struct packed {
      logic [7:0] popped_id;
      logic       pop_valid;
      logic       insert_accepted;
      logic [3:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [15:0] deadline;
   } entry_type;
endpackage

FILE: src/dpq_if.sv
// Valid/ready channel interfaces for the deadline priority queue.
// Depends on dpq_pkg.
interface dpq_req_if;
   logic            valid;
   logic            ready;
   dpq_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dpq_rsp_if;
   logic            valid;
   logic            ready;
   dpq_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/deadline_priority_queue.sv
// Channel  | Dir | Payload
// req      | in  | action, task_id, deadline, compute_time
// rsp      | out | popped_id, pop_valid, insert_accepted, occupancy
// Insert: one memory write when the queue is not full; the result is registered.
// Pop: one memory read per cycle scans slots for the minimum, then a read
//   and a write move each later slot down by one; the result is registered.
// Reset clears the count and control only; the slot memory is not cleared.
// A waiting result stalls the next item until rsp is taken.
// Top level of the deadline priority queue; depends on dpq_pkg, dpq_if and
// deadline_priority_queue_defines.svh.
`include "deadline_priority_queue_defines.svh"
module deadline_priority_queue #(
   parameter int unsigned QUEUE_DEPTH = dpq_pkg::DefaultDepth
) (
   input logic   clock,
   input logic   reset,
   dpq_req_if.sink   req,
   dpq_rsp_if.source rsp
);
   import dpq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [2:0] StIdle = 3'd0, StScan = 3'd1, StScanEnd = 3'd2,
                          StShift = 3'd3, StShiftWr = 3'd4, StDone = 3'd5;

   entry_type   mem [QUEUE_DEPTH];
   entry_type   rd_data;
   logic        rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   entry_type   wr_data;

   logic [2:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] best_ff, best_in;
   entry_type   best_e_ff, best_e_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end

   assign req.ready = (state_ff == StIdle) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      best_in = best_ff;
      best_e_in = best_e_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in = rsp_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      case (state_ff)
         StIdle: begin
            if (req.valid && req.ready) begin
               rsp_in = '0;
               if (req.payload.action == ActInsert) begin
                  if (count_ff < CW'(QUEUE_DEPTH)) begin
                     wr_en = 1'b1;
                     wr_addr = count_ff[AW-1:0];
                     wr_data.task_id = req.payload.task_id;
                     wr_data.deadline = (req.payload.compute_time == '0)
                        ? IdleDeadline : req.payload.deadline;
                     count_in = count_ff + 1'b1;
                     rsp_in.insert_accepted = 1'b1;
                  end
                  rsp_in.occupancy = 4'(count_in);
                  rsp_valid_in = 1'b1;
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  rd_en = 1'b1;
                  rd_addr = '0;
                  idx_in = CW'(1);
                  best_in = '0;
                  best_e_in.deadline = '1;
                  state_in = StScan;
               end
            end
         end
         StScan: begin
            // rd_data holds slot idx_ff-1
            if (rd_data.deadline < best_e_ff.deadline || idx_ff == CW'(1)) begin
               best_e_in = rd_data;
               best_in = AW'(idx_ff - 1'b1);
            end
            if (idx_ff == count_ff) begin
               state_in = StScanEnd;
            end else begin
               rd_en = 1'b1;
               rd_addr = idx_ff[AW-1:0];
               idx_in = idx_ff + 1'b1;
            end
         end
         StScanEnd: begin
            rsp_in.popped_id = best_e_ff.task_id;
            rsp_in.pop_valid = 1'b1;
            idx_in = CW'(best_ff) + 1'b1;
            state_in = StShift;
         end
         StShift: begin
            if (idx_ff >= count_ff) begin
               count_in = count_ff - 1'b1;
               rsp_in.occupancy = 4'(count_in);
               state_in = StDone;
            end else begin
               rd_en = 1'b1;
               rd_addr = idx_ff[AW-1:0];
               state_in = StShiftWr;
            end
         end
         StShiftWr: begin
            wr_en = 1'b1;
            wr_addr = AW'(idx_ff - 1'b1);
            wr_data = rd_data;
            idx_in = idx_ff + 1'b1;
            state_in = StShift;
         end
         StDone: begin
            rsp_valid_in = 1'b1;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      best_ff <= best_in;
      best_e_ff <= best_e_in;
      rsp_ff <= rsp_in;
   end

   `DPQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(QUEUE_DEPTH))
   `DPQ_ASSERT_IMP(a_busy_no_rsp, clock, reset, state_ff != StIdle, !rsp_valid_ff)
   `DPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp.ready,
      rsp_valid_ff && $stable(rsp_ff))
   `DPQ_ASSERT_IMP(a_pop_nonempty, clock, reset, state_ff == StScan, count_ff != '0)
endmodule
